@@ sv/cascaded_attitude_pid_quad_mixer_top_defines.svh @@
// ----------------------------------------------------------------------------
// cascaded attitude pid quad mixer - assertion macros
// Shared concurrent check macros for the controller and its mixer stage.
// ----------------------------------------------------------------------------
`ifndef CASCADED_ATTITUDE_PID_QUAD_MIXER_TOP_DEFINES_SVH
`define CASCADED_ATTITUDE_PID_QUAD_MIXER_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define CAPQM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("capqm: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define CAPQM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("capqm: next-cycle check failed");

`endif

@@ sv/capqm_pkg.sv @@
// ----------------------------------------------------------------------------
// capqm_pkg
// Types, register codes and constants of the cascaded attitude controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package capqm_pkg;

  localparam int FRAC_BITS_DEF   = 8;
  localparam int STATE_WIDTH_DEF = 32;

  localparam int FIELD_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int THR_W     = 12;
  localparam int CFG_IDX_W = 3;

  // loop limits in whole degrees
  localparam int ANGLE_INC_DEG  = 10;
  localparam int ANGLE_INT_DEG  = 1000;
  localparam int ANGLE_ZERO_DEG = 5;
  localparam int RATE_INC_DEG   = 50;
  localparam int RATE_INT_DEG   = 5000;
  localparam int RATE_ZERO_DEG  = 40;

  localparam logic [GAIN_W-1:0] ANGLE_KP_RST = 16'd2560;
  localparam logic [GAIN_W-1:0] ANGLE_KI_RST = 16'd0;
  localparam logic [GAIN_W-1:0] ANGLE_KD_RST = 16'd0;
  localparam logic [GAIN_W-1:0] RATE_KP_RST  = 16'd1152;
  localparam logic [GAIN_W-1:0] RATE_KI_RST  = 16'd0;
  localparam logic [GAIN_W-1:0] RATE_KD_RST  = 16'd5120;
  localparam logic [THR_W-1:0]  BASE_RST     = 12'd1100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_KP      = 3'd0,
    REG_ANGLE_KI      = 3'd1,
    REG_ANGLE_KD      = 3'd2,
    REG_RATE_KP       = 3'd3,
    REG_RATE_KI       = 3'd4,
    REG_RATE_KD       = 3'd5,
    REG_BASE_THROTTLE = 3'd6,
    REG_MOTORS_LOCKED = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] roll_angle;
    logic signed [FIELD_W-1:0] pitch_angle;
    logic signed [FIELD_W-1:0] roll_target;
    logic signed [FIELD_W-1:0] pitch_target;
    logic signed [FIELD_W-1:0] roll_rate;
    logic signed [FIELD_W-1:0] pitch_rate;
  } meas_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] motor_one;
    logic signed [FIELD_W-1:0] motor_two;
    logic signed [FIELD_W-1:0] motor_three;
    logic signed [FIELD_W-1:0] motor_four;
  } motors_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic accum;
  } mac_ctl_t;

  typedef struct packed {
    logic load;
    logic locked;
  } mix_ctl_t;

  function automatic longint scale_lim(int deg, int frac);
    return longint'(deg) <<< frac;
  endfunction

  function automatic longint sat_max(int w);
    return (64'sd1 <<< (w - 1)) - 64'sd1;
  endfunction

endpackage

@@ sv/capqm_mac.sv @@
// ----------------------------------------------------------------------------
// capqm_mac
// Shared gain multiplier with a floor-shifting accumulator and output clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module capqm_mac import capqm_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic                          clk,
  input  mac_ctl_t                      ctl,
  input  logic [GAIN_W-1:0]             gain,
  input  logic signed [STATE_WIDTH-1:0] opnd,
  output logic signed [STATE_WIDTH-1:0] res
);

  localparam int PW = STATE_WIDTH + GAIN_W + 1;
  localparam int AW = PW - GAIN_FRAC + 2;
  localparam logic signed [AW-1:0] RES_MAX = AW'(sat_max(STATE_WIDTH));
  localparam logic signed [AW-1:0] RES_MIN = AW'(-sat_max(STATE_WIDTH) - 64'sd1);

  logic signed [PW-1:0] prod_full;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] acc;

  assign prod_full = $signed({1'b0, gain}) * opnd;
  // arithmetic shift floors each product on its own
  assign term = AW'(prod >>> GAIN_FRAC);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= prod_full;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.accum) begin
      acc <= acc + term;
    end
  end

  always_comb begin
    if (acc > RES_MAX) begin
      res = STATE_WIDTH'(RES_MAX);
    end else if (acc < RES_MIN) begin
      res = STATE_WIDTH'(RES_MIN);
    end else begin
      res = STATE_WIDTH'(acc);
    end
  end

endmodule

@@ sv/capqm_mix.sv @@
// ----------------------------------------------------------------------------
// capqm_mix
// X mixer for four motors with saturation, and the output item register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cascaded_attitude_pid_quad_mixer_top_defines.svh"

module capqm_mix import capqm_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mix_ctl_t                      ctl,
  input  logic [THR_W-1:0]              base,
  input  logic signed [STATE_WIDTH-1:0] roll,
  input  logic signed [STATE_WIDTH-1:0] pitch,
  output logic                          ready,
  output logic                          motor_valid,
  input  logic                          motor_stall,
  output motors_t                       motors
);

  localparam int BW = THR_W + FRAC_BITS + 1;
  localparam int MW = ((STATE_WIDTH > BW) ? STATE_WIDTH : BW) + 2;
  localparam logic signed [MW-1:0] M_MAX  = MW'(32767);
  localparam logic signed [MW-1:0] M_MIN  = MW'(-32768);
  localparam logic signed [MW-1:0] F_MASK = MW'((64'sd1 <<< FRAC_BITS) - 64'sd1);

  logic signed [MW-1:0] b_fix;
  logic signed [MW-1:0] p_ext;
  logic signed [MW-1:0] r_ext;
  motors_t              mixed;

  // truncate toward zero to whole units, then clamp to int16
  function automatic logic signed [FIELD_W-1:0] motor_of(logic signed [MW-1:0] s);
    logic signed [MW-1:0] adj;
    logic signed [MW-1:0] q;
    adj = s + (s[MW-1] ? F_MASK : MW'(0));
    q   = adj >>> FRAC_BITS;
    if (q > M_MAX) begin
      return FIELD_W'(M_MAX);
    end else if (q < M_MIN) begin
      return FIELD_W'(M_MIN);
    end
    return FIELD_W'(q);
  endfunction

  assign b_fix = MW'({1'b0, base}) <<< FRAC_BITS;
  assign p_ext = MW'(pitch);
  assign r_ext = MW'(roll);

  always_comb begin
    if (ctl.locked) begin
      mixed.motor_one   = $signed(FIELD_W'(base));
      mixed.motor_two   = $signed(FIELD_W'(base));
      mixed.motor_three = $signed(FIELD_W'(base));
      mixed.motor_four  = $signed(FIELD_W'(base));
    end else begin
      mixed.motor_one   = motor_of(b_fix + p_ext + r_ext);
      mixed.motor_two   = motor_of(b_fix + p_ext - r_ext);
      mixed.motor_three = motor_of(b_fix - p_ext - r_ext);
      mixed.motor_four  = motor_of(b_fix - p_ext + r_ext);
    end
  end

  assign ready = !motor_valid || !motor_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_valid <= 1'b0;
    end else if (ctl.load) begin
      motor_valid <= 1'b1;
    end else if (!motor_stall) begin
      motor_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      motors <= mixed;
    end
  end

  `CAPQM_ASSERT_SAME(a_load_when_ready, clk, rst, ctl.load, ready)
  `CAPQM_ASSERT_NEXT(a_locked_base, clk, rst, ctl.load && ctl.locked, motors.motor_three == $past({4'b0, base}))

endmodule

@@ sv/cascaded_attitude_pid_quad_mixer_top.sv @@
// ----------------------------------------------------------------------------
// cascaded_attitude_pid_quad_mixer_top
// Cascaded angle/rate PID for roll and pitch on one shared multiplier,
// followed by an X mixer for four motors.
// ----------------------------------------------------------------------------
//  channel   | signals                         | direction
//  ----------+---------------------------------+----------
//  meas      | meas_valid, meas_stall, meas    | in
//  motors    | motor_valid, motor_stall, motors| out
//  config    | cfg_we, cfg_index, cfg_data     | in
//
//  an item is accepted in idle, then runs four loops on the shared multiplier,
//  each through error, three products, accumulate and clamp, then the mix step.
//  meas_stall is high from acceptance until the mix cycle has passed.
//  the mix cycle waits while the output register holds an item under stall.
//  reset (rst, synchronous) clears gains to defaults and all loop state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cascaded_attitude_pid_quad_mixer_top_defines.svh"

module cascaded_attitude_pid_quad_mixer_top import capqm_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 meas_valid,
  output logic                 meas_stall,
  input  meas_t                meas,
  output logic                 motor_valid,
  input  logic                 motor_stall,
  output motors_t              motors,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  localparam int SW  = STATE_WIDTH;
  localparam int SW1 = STATE_WIDTH + 1;

  localparam longint ST_MAX = sat_max(SW);
  localparam longint ST_MIN = -ST_MAX - 64'sd1;
  localparam longint A_INT  = scale_lim(ANGLE_INT_DEG, FRAC_BITS);
  localparam longint R_INT  = scale_lim(RATE_INT_DEG, FRAC_BITS);
  localparam longint A_HI   = (A_INT < ST_MAX) ? A_INT : ST_MAX;
  localparam longint A_LO   = (-A_INT > ST_MIN) ? -A_INT : ST_MIN;
  localparam longint R_HI   = (R_INT < ST_MAX) ? R_INT : ST_MAX;
  localparam longint R_LO   = (-R_INT > ST_MIN) ? -R_INT : ST_MIN;

  localparam logic signed [SW1-1:0] ST_MAX_V = SW1'(ST_MAX);
  localparam logic signed [SW1-1:0] ST_MIN_V = SW1'(ST_MIN);
  localparam logic signed [SW1-1:0] A_HI_V   = SW1'(A_HI);
  localparam logic signed [SW1-1:0] A_LO_V   = SW1'(A_LO);
  localparam logic signed [SW1-1:0] R_HI_V   = SW1'(R_HI);
  localparam logic signed [SW1-1:0] R_LO_V   = SW1'(R_LO);
  localparam logic signed [SW-1:0]  A_HI_SW  = SW'(A_HI);
  localparam logic signed [SW-1:0]  A_LO_SW  = SW'(A_LO);

  localparam logic signed [SW-1:0] A_INC_V  = SW'(scale_lim(ANGLE_INC_DEG, FRAC_BITS));
  localparam logic signed [SW-1:0] R_INC_V  = SW'(scale_lim(RATE_INC_DEG, FRAC_BITS));
  localparam logic signed [SW-1:0] A_ZERO_V = SW'(scale_lim(ANGLE_ZERO_DEG, FRAC_BITS));
  localparam logic signed [SW-1:0] R_ZERO_V = SW'(scale_lim(RATE_ZERO_DEG, FRAC_BITS));

  localparam logic signed [17:0] F_MASK18 = 18'((64'sd1 <<< FRAC_BITS) - 64'sd1);
  localparam logic signed [17:0] ONE18    = 18'(64'sd1 <<< FRAC_BITS);

  localparam logic [1:0] LOOP_ROLL_ANGLE  = 2'd0;
  localparam logic [1:0] LOOP_ROLL_RATE   = 2'd1;
  localparam logic [1:0] LOOP_PITCH_RATE  = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ERR  = 8'b0000_0010,
    S_MP   = 8'b0000_0100,
    S_MI   = 8'b0000_1000,
    S_MD   = 8'b0001_0000,
    S_AC   = 8'b0010_0000,
    S_SAT  = 8'b0100_0000,
    S_MIX  = 8'b1000_0000
  } state_t;

  // configuration
  logic [GAIN_W-1:0] angle_kp;
  logic [GAIN_W-1:0] angle_ki;
  logic [GAIN_W-1:0] angle_kd;
  logic [GAIN_W-1:0] rate_kp;
  logic [GAIN_W-1:0] rate_ki;
  logic [GAIN_W-1:0] rate_kd;
  logic [THR_W-1:0]  base_throttle;
  logic              motors_locked;

  // sequencer
  state_t     state;
  state_t     state_next;
  logic [1:0] loop_sel;
  logic [1:0] loop_sel_next;

  // per-item and loop state
  meas_t                  meas_hold;
  logic signed [SW-1:0]   integ [4];
  logic signed [SW-1:0]   last_err [4];
  logic signed [SW-1:0]   err_val;
  logic signed [SW-1:0]   int_val;
  logic signed [SW-1:0]   dif_val;
  logic signed [SW-1:0]   loop_out;
  logic signed [SW-1:0]   roll_drv;
  logic signed [SW-1:0]   pitch_drv;

  // error path
  logic                   is_rate;
  logic                   is_pitch;
  logic signed [FIELD_W-1:0] ang_sel;
  logic signed [FIELD_W-1:0] tgt_sel;
  logic signed [FIELD_W-1:0] rate_sel;
  logic signed [17:0]     ang18;
  logic signed [17:0]     ang_whole;
  logic signed [18:0]     e_ang;
  logic signed [SW-1:0]   e_rate;
  logic signed [SW-1:0]   e_cur;
  logic signed [SW-1:0]   inc_lim;
  logic signed [SW-1:0]   zero_lim;
  logic signed [SW1-1:0]  int_hi;
  logic signed [SW1-1:0]  int_lo;
  logic signed [SW-1:0]   inc;
  logic signed [SW1-1:0]  int_sum;
  logic signed [SW-1:0]   int_new;
  logic signed [SW-1:0]   dif_new;

  // shared unit and mixer hookup
  mac_ctl_t               mac_ctl;
  logic [GAIN_W-1:0]      mac_gain;
  logic signed [SW-1:0]   mac_opnd;
  logic signed [SW-1:0]   mac_res;
  mix_ctl_t               mix_ctl;
  logic                   mix_rdy;

  function automatic logic signed [SW-1:0] sat_sw(logic signed [SW1-1:0] x);
    if (x > ST_MAX_V) begin
      return SW'(ST_MAX_V);
    end else if (x < ST_MIN_V) begin
      return SW'(ST_MIN_V);
    end
    return SW'(x);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_kp      <= ANGLE_KP_RST;
      angle_ki      <= ANGLE_KI_RST;
      angle_kd      <= ANGLE_KD_RST;
      rate_kp       <= RATE_KP_RST;
      rate_ki       <= RATE_KI_RST;
      rate_kd       <= RATE_KD_RST;
      base_throttle <= BASE_RST;
      motors_locked <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ANGLE_KP:      angle_kp      <= cfg_data;
        REG_ANGLE_KI:      angle_ki      <= cfg_data;
        REG_ANGLE_KD:      angle_kd      <= cfg_data;
        REG_RATE_KP:       rate_kp       <= cfg_data;
        REG_RATE_KI:       rate_ki       <= cfg_data;
        REG_RATE_KD:       rate_kd       <= cfg_data;
        REG_BASE_THROTTLE: base_throttle <= cfg_data[THR_W-1:0];
        REG_MOTORS_LOCKED: motors_locked <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // loop order: roll angle, roll rate, pitch angle, pitch rate
  assign is_rate  = loop_sel[0];
  assign is_pitch = loop_sel[1];

  always_comb begin
    ang_sel  = is_pitch ? meas_hold.pitch_angle  : meas_hold.roll_angle;
    tgt_sel  = is_pitch ? meas_hold.pitch_target : meas_hold.roll_target;
    rate_sel = is_pitch ? meas_hold.pitch_rate   : meas_hold.roll_rate;

    // whole degrees, truncated toward zero
    ang18     = 18'(ang_sel);
    ang_whole = (ang18 & ~F_MASK18) +
                (((ang18 < 0) && ((ang18 & F_MASK18) != '0)) ? ONE18 : 18'sd0);
    e_ang     = 19'(tgt_sel) - 19'(ang_whole);
    e_rate    = sat_sw(SW1'(rate_sel) + SW1'(loop_out));
    e_cur     = is_rate ? e_rate : SW'(e_ang);

    inc_lim  = is_rate ? R_INC_V  : A_INC_V;
    zero_lim = is_rate ? R_ZERO_V : A_ZERO_V;
    int_hi   = is_rate ? R_HI_V   : A_HI_V;
    int_lo   = is_rate ? R_LO_V   : A_LO_V;

    if (e_cur > inc_lim) begin
      inc = inc_lim;
    end else if (e_cur < -inc_lim) begin
      inc = -inc_lim;
    end else begin
      inc = e_cur;
    end

    int_sum = SW1'(integ[loop_sel]) + SW1'(inc);
    if ((e_cur > zero_lim) || (e_cur < -zero_lim)) begin
      int_new = '0;
    end else if (int_sum > int_hi) begin
      int_new = SW'(int_hi);
    end else if (int_sum < int_lo) begin
      int_new = SW'(int_lo);
    end else begin
      int_new = SW'(int_sum);
    end

    dif_new = sat_sw(SW1'(e_cur) - SW1'(last_err[loop_sel]));
  end

  always_comb begin
    state_next    = state;
    loop_sel_next = loop_sel;
    case (state)
      S_IDLE: begin
        if (meas_valid) begin
          state_next    = S_ERR;
          loop_sel_next = LOOP_ROLL_ANGLE;
        end
      end
      S_ERR: state_next = S_MP;
      S_MP:  state_next = S_MI;
      S_MI:  state_next = S_MD;
      S_MD:  state_next = S_AC;
      S_AC:  state_next = S_SAT;
      S_SAT: begin
        if (loop_sel == LOOP_PITCH_RATE) begin
          state_next = S_MIX;
        end else begin
          state_next    = S_ERR;
          loop_sel_next = loop_sel + 2'd1;
        end
      end
      S_MIX: begin
        if (mix_rdy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      loop_sel <= LOOP_ROLL_ANGLE;
    end else begin
      state    <= state_next;
      loop_sel <= loop_sel_next;
    end
  end

  assign meas_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        integ[k]    <= '0;
        last_err[k] <= '0;
      end
    end else if (state == S_ERR) begin
      integ[loop_sel]    <= int_new;
      last_err[loop_sel] <= e_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (meas_valid && !meas_stall) begin
      meas_hold <= meas;
    end
    if (state == S_ERR) begin
      err_val <= e_cur;
      int_val <= int_new;
      dif_val <= dif_new;
    end
    if (state == S_SAT) begin
      loop_out <= mac_res;
      if (loop_sel == LOOP_ROLL_RATE) begin
        roll_drv <= mac_res;
      end
      if (loop_sel == LOOP_PITCH_RATE) begin
        pitch_drv <= mac_res;
      end
    end
  end

  always_comb begin
    mac_ctl.clear = (state == S_ERR);
    mac_ctl.load  = (state == S_MP) || (state == S_MI) || (state == S_MD);
    mac_ctl.accum = (state == S_MI) || (state == S_MD) || (state == S_AC);
    case (state)
      S_MP: begin
        mac_gain = is_rate ? rate_kp : angle_kp;
        mac_opnd = err_val;
      end
      S_MI: begin
        mac_gain = is_rate ? rate_ki : angle_ki;
        mac_opnd = int_val;
      end
      default: begin
        mac_gain = is_rate ? rate_kd : angle_kd;
        mac_opnd = dif_val;
      end
    endcase
  end

  capqm_mac #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .gain (mac_gain),
    .opnd (mac_opnd),
    .res  (mac_res)
  );

  assign mix_ctl.load   = (state == S_MIX) && mix_rdy;
  assign mix_ctl.locked = motors_locked;

  capqm_mix #(
    .FRAC_BITS   (FRAC_BITS),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_mix (
    .clk         (clk),
    .rst         (rst),
    .ctl         (mix_ctl),
    .base        (base_throttle),
    .roll        (roll_drv),
    .pitch       (pitch_drv),
    .ready       (mix_rdy),
    .motor_valid (motor_valid),
    .motor_stall (motor_stall),
    .motors      (motors)
  );

  `CAPQM_ASSERT_NEXT(a_accept_starts, clk, rst, meas_valid && !meas_stall, state == S_ERR && loop_sel == LOOP_ROLL_ANGLE)
  `CAPQM_ASSERT_SAME(a_integ_bound, clk, rst, 1'b1, integ[LOOP_ROLL_ANGLE] <= A_HI_SW && integ[LOOP_ROLL_ANGLE] >= A_LO_SW)
  `CAPQM_ASSERT_NEXT(a_mix_delivers, clk, rst, state == S_MIX && mix_rdy, motor_valid && state == S_IDLE)

endmodule
